// ===== rtl/core/extremum_linear_interpolator_core_assert.svh =====
// ----------------------------------------------------------------------------
// extremum linear interpolator assertion macros
// concurrent checks clocked by clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef EXTREMUM_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define EXTREMUM_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ELI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ELI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/eli_pkg.sv =====
// ----------------------------------------------------------------------------
// eli_pkg
// shared constants and controller/datapath signal groups
// ----------------------------------------------------------------------------
`default_nettype none

package eli_pkg;

	localparam int ELI_MAX_SEGMENT = 32;
	localparam int ELI_SAMPLE_BITS = 16;

	typedef struct packed {
		logic take;
		logic load_end;
		logic div_start;
		logic div_step;
		logic emit;
		logic emit_final;
	} eli_cmd_t;

	typedef struct packed {
		logic brk;
		logic rec_end;
		logic end_seg;
		logic seg_empty;
		logic div_last;
		logic seg_last;
		logic out_free;
	} eli_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/eli_in_if.sv =====
// ----------------------------------------------------------------------------
// eli_in_if
// input sample channel: one word is a sample and its record end mark
// ----------------------------------------------------------------------------
`default_nettype none

interface eli_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          record_end;

	modport source (output valid, output sample, output record_end, input ready);
	modport sink (input valid, input sample, input record_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eli_out_if.sv =====
// ----------------------------------------------------------------------------
// eli_out_if
// result channel: one word is an interpolated sample with its marks
// ----------------------------------------------------------------------------
`default_nettype none

interface eli_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          run_last;
	logic                          record_done;

	modport source (output valid, output value, output run_last, output record_done,
		input ready);
	modport sink (input valid, input value, input run_last, input record_done,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/extremum_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// extremum_linear_interpolator_core
// redraws each audio record as straight lines between its local extrema
// ----------------------------------------------------------------------------
// One sample word is taken at a time. A word that closes no segment goes
// through ST_CHECK back to ST_IDLE. A word that closes a segment of d samples
// is followed by d result words: the slope of each segment comes from a
// restoring divider that yields one quotient bit per cycle, then one result
// word leaves per cycle while the output side is ready. The record's final
// word adds one more segment and the closing word. The output register holds
// a finished word while the next sample is already taken.
`default_nettype none

`include "extremum_linear_interpolator_core_assert.svh"

module extremum_linear_interpolator_core import eli_pkg::*; #(
	parameter int MAX_SEGMENT = ELI_MAX_SEGMENT,
	parameter int SAMPLE_BITS = ELI_SAMPLE_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	eli_in_if.sink    samples,
	eli_out_if.source results
);
	eli_cmd_t cmd;
	eli_sts_t sts;

	eli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	eli_dp #(
		.MAX_SEGMENT (MAX_SEGMENT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.samples (samples),
		.results (results)
	);

	`ELI_ASSERT_NOW(a_done_is_last, results.valid && results.record_done, results.run_last, "record end word not marked last")
	`ELI_ASSERT_NOW(a_emit_has_room, cmd.emit || cmd.emit_final, sts.out_free, "word written over a pending output")
	`ELI_ASSERT_NEXT(a_end_blocks_input, samples.valid && samples.ready && samples.record_end, !samples.ready, "input taken right after a record end")
endmodule

`default_nettype wire

// ===== rtl/core/eli_div.sv =====
// ----------------------------------------------------------------------------
// eli_div
// restoring unsigned divider, one quotient bit per step
// ----------------------------------------------------------------------------
`default_nettype none

module eli_div import eli_pkg::*; #(
	parameter int NB = ELI_SAMPLE_BITS,
	parameter int DW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          step,
	input  wire logic [NB-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [NB-1:0] quo,
	output logic      [DW-1:0] rem,
	output logic               last
);
	localparam int CW = $clog2(NB);

	logic [NB-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   part;
	logic          ge;

	assign part = {rem_q, dvd_q[NB-1]};
	assign ge   = part >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NB - 1);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[NB-2:0], ge};
			rem_q <= ge ? DW'(part - {1'b0, divisor}) : part[DW-1:0];
		end
	end

	assign quo  = dvd_q;
	assign rem  = rem_q;
	assign last = cnt_q == '0;
endmodule

`default_nettype wire

// ===== rtl/core/eli_dp.sv =====
// ----------------------------------------------------------------------------
// eli_dp
// datapath: sample history, breakpoint test, segment stepper, output word
// ----------------------------------------------------------------------------
`default_nettype none

module eli_dp import eli_pkg::*; #(
	parameter int MAX_SEGMENT = ELI_MAX_SEGMENT,
	parameter int SAMPLE_BITS = ELI_SAMPLE_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire eli_cmd_t cmd,
	output eli_sts_t      sts,
	eli_in_if.sink        samples,
	eli_out_if.source     results
);
	localparam int W  = SAMPLE_BITS;
	localparam int DW = $clog2(MAX_SEGMENT + 1);

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	logic signed [W-1:0] older_q, middle_q, anchor_q, x_q, y0_q, y1_q;
	logic [1:0]          seen_q;
	logic [DW-1:0]       dist_q, d_q, k_q, r_q;
	logic [W-1:0]        q_q;
	logic                end_q, brk_q, end_seg_q, neg_q;
	logic                out_valid_q, out_run_last_q, out_done_q;
	logic signed [W-1:0] out_value_q;

	logic signed [W:0]   left, right, diff, sv, val;
	logic                ext, brk_now;
	logic [W-1:0]        mag, quo;
	logic [DW-1:0]       rem;
	logic                div_last;
	logic [DW:0]         r_sum;
	logic                wrap;

	// breakpoint test on the incoming sample
	assign left  = {middle_q[W-1], middle_q} - {older_q[W-1], older_q};
	assign right = {samples.sample[W-1], samples.sample} - {middle_q[W-1], middle_q};
	assign ext   = (!left[W] && left != '0 && right[W]) ||
		(left[W] && !right[W] && right != '0);
	assign brk_now = (seen_q == SEEN_TWO) && (ext || dist_q >= DW'(MAX_SEGMENT));

	// segment slope magnitude for the divider
	assign diff = {y1_q[W-1], y1_q} - {y0_q[W-1], y0_q};
	assign mag  = diff[W] ? W'(-diff) : diff[W-1:0];

	eli_div #(
		.NB (W),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (mag),
		.divisor  (d_q),
		.quo      (quo),
		.rem      (rem),
		.last     (div_last)
	);

	// running quotient and remainder of |diff|*k/d
	assign r_sum = {1'b0, r_q} + {1'b0, rem};
	assign wrap  = r_sum >= {1'b0, d_q};
	assign sv    = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	assign val   = {y0_q[W-1], y0_q} + sv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			middle_q <= '0;
			anchor_q <= '0;
			seen_q   <= SEEN_NONE;
			dist_q   <= '0;
			end_q    <= 1'b0;
			brk_q    <= 1'b0;
		end else if (cmd.take) begin
			end_q <= samples.record_end;
			brk_q <= brk_now;
			case (seen_q)
				SEEN_NONE: begin
					middle_q <= samples.sample;
					dist_q   <= '0;
					seen_q   <= SEEN_ONE;
				end
				SEEN_ONE: begin
					older_q  <= middle_q;
					middle_q <= samples.sample;
					dist_q   <= DW'(1);
					seen_q   <= SEEN_TWO;
				end
				default: begin
					older_q  <= middle_q;
					middle_q <= samples.sample;
					if (brk_now) begin
						anchor_q <= middle_q;
						dist_q   <= DW'(1);
					end else begin
						dist_q <= dist_q + 1'b1;
					end
				end
			endcase
		end else if (cmd.emit_final) begin
			older_q  <= '0;
			middle_q <= '0;
			anchor_q <= '0;
			seen_q   <= SEEN_NONE;
			dist_q   <= '0;
			end_q    <= 1'b0;
			brk_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q       <= samples.sample;
			y0_q      <= anchor_q;
			y1_q      <= middle_q;
			d_q       <= dist_q;
			end_seg_q <= 1'b0;
		end else if (cmd.load_end) begin
			y0_q      <= anchor_q;
			y1_q      <= x_q;
			d_q       <= dist_q;
			end_seg_q <= 1'b1;
		end
		if (cmd.div_start) begin
			neg_q <= diff[W];
			q_q   <= '0;
			r_q   <= '0;
			k_q   <= '0;
		end else if (cmd.emit) begin
			q_q <= q_q + quo + W'(wrap);
			r_q <= wrap ? DW'(r_sum - {1'b0, d_q}) : r_sum[DW-1:0];
			k_q <= k_q + 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q    <= val[W-1:0];
			out_run_last_q <= sts.seg_last && !end_q;
			out_done_q     <= 1'b0;
		end else if (cmd.emit_final) begin
			out_value_q    <= x_q;
			out_run_last_q <= 1'b1;
			out_done_q     <= 1'b1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.value       = out_value_q;
	assign results.run_last    = out_run_last_q;
	assign results.record_done = out_done_q;

	assign sts.brk       = brk_q;
	assign sts.rec_end   = end_q;
	assign sts.end_seg   = end_seg_q;
	assign sts.seg_empty = d_q == '0;
	assign sts.div_last  = div_last;
	assign sts.seg_last  = k_q == d_q - 1'b1;
	assign sts.out_free  = !out_valid_q || results.ready;
endmodule

`default_nettype wire

// ===== rtl/core/eli_ctrl.sv =====
// ----------------------------------------------------------------------------
// eli_ctrl
// sequencer: take word, divide per segment, step out segment words
// ----------------------------------------------------------------------------
`default_nettype none

module eli_ctrl import eli_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire eli_sts_t sts,
	output eli_cmd_t      cmd
);
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_CHECK     = 3'd1;
	localparam logic [2:0] ST_LOAD_END  = 3'd2;
	localparam logic [2:0] ST_DIV_START = 3'd3;
	localparam logic [2:0] ST_DIV       = 3'd4;
	localparam logic [2:0] ST_EMIT      = 3'd5;
	localparam logic [2:0] ST_FINAL     = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.brk) begin
					state_d = ST_DIV_START;
				end else if (sts.rec_end) begin
					state_d = ST_LOAD_END;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD_END: begin
				cmd.load_end = 1'b1;
				state_d      = ST_DIV_START;
			end
			ST_DIV_START: begin
				if (sts.seg_empty) begin
					state_d = ST_FINAL;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.seg_last) begin
						if (sts.end_seg) begin
							state_d = ST_FINAL;
						end else if (sts.rec_end) begin
							state_d = ST_LOAD_END;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

`default_nettype wire
